// File: rtl/core/dpmpp_pkg.sv
// shared types, register codes and helpers for the dpm-solver++ update pipeline
package dpmpp_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int NUM_STAGES = 7;
  localparam int SAT_IN_W   = 80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA_CUR,
    REG_NORM_CUR,
    REG_SAMP_WEIGHT,
    REG_STEP_COEF,
    REG_INV_RATIO,
    REG_HIST_ORDER,
    REG_FIRST_FINAL,
    REG_FINAL_STEP
  } cfg_reg_t;

  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_t;

  typedef struct packed {
    logic [23:0]        sigma_cur;
    logic [23:0]        norm_cur;
    logic [16:0]        samp_weight;
    logic signed [16:0] step_coef;
    logic signed [24:0] inv_ratio;
    logic [1:0]         hist_order;
    logic               first_final;
    logic               final_step;
  } cfg_t;

  typedef struct packed {
    logic second;
    logic ovf;
    logic last;
  } flags_t;

  localparam logic [23:0]        RST_SIGMA_CUR    = 24'd0;
  localparam logic [23:0]        RST_NORM_CUR     = 24'd65536;
  localparam logic [16:0]        RST_SAMP_WEIGHT  = 17'd65536;
  localparam logic signed [16:0] RST_STEP_COEF    = 17'sd0;
  localparam logic signed [24:0] RST_INV_RATIO    = 25'sd65536;
  localparam logic [1:0]         RST_HIST_ORDER   = 2'd2;
  localparam logic               RST_FIRST_FINAL  = 1'b1;
  localparam logic               RST_FINAL_STEP   = 1'b0;
  localparam logic [1:0]         MIN_SECOND_ORDER = 2'd2;

  // clamp a wide signed value into 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    logic fits;
    fits = (&x[SAT_IN_W-1:DATA_W-1]) | ~(|x[SAT_IN_W-1:DATA_W-1]);
    if (fits) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_IN_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/core/dpmpp_ctrl.sv
// configuration registers and per-step element index / warm-up tracking
module dpmpp_ctrl #(
  parameter int MAX_ELEMENTS = 16384,
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dpmpp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dpmpp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             accept,
  input  logic                             func,
  input  logic                             last_element,
  output dpmpp_pkg::cfg_t                  cfg,
  output dpmpp_pkg::flags_t                flags,
  output logic [IDX_W-1:0]                 idx
);

  dpmpp_pkg::cfg_t  cfg_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic [1:0]       warm_r, warm_nxt;

  // second order needs a stored history and no forced first-order final step
  always_comb begin
    flags.second = !ovf_r && (warm_r != 2'd0) &&
                   (cfg_r.hist_order >= dpmpp_pkg::MIN_SECOND_ORDER) &&
                   !(cfg_r.first_final && cfg_r.final_step);
    flags.ovf    = ovf_r;
    flags.last   = last_element;
  end

  assign cfg = cfg_r;
  assign idx = idx_r;

  always_comb begin
    idx_nxt  = idx_r;
    ovf_nxt  = ovf_r;
    warm_nxt = warm_r;
    if (accept) begin
      if (func == dpmpp_pkg::FUNC_CLEAR) begin
        idx_nxt  = '0;
        ovf_nxt  = 1'b0;
        warm_nxt = 2'd0;
      end else begin
        if (!ovf_r) begin
          if (idx_r == IDX_W'(MAX_ELEMENTS - 1)) begin
            ovf_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (last_element) begin
          idx_nxt = '0;
          ovf_nxt = 1'b0;
          if (warm_r < cfg_r.hist_order) begin
            warm_nxt = warm_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r             <= '0;
      ovf_r             <= 1'b0;
      warm_r            <= 2'd0;
      cfg_r.sigma_cur   <= dpmpp_pkg::RST_SIGMA_CUR;
      cfg_r.norm_cur    <= dpmpp_pkg::RST_NORM_CUR;
      cfg_r.samp_weight <= dpmpp_pkg::RST_SAMP_WEIGHT;
      cfg_r.step_coef   <= dpmpp_pkg::RST_STEP_COEF;
      cfg_r.inv_ratio   <= dpmpp_pkg::RST_INV_RATIO;
      cfg_r.hist_order  <= dpmpp_pkg::RST_HIST_ORDER;
      cfg_r.first_final <= dpmpp_pkg::RST_FIRST_FINAL;
      cfg_r.final_step  <= dpmpp_pkg::RST_FINAL_STEP;
    end else begin
      idx_r  <= idx_nxt;
      ovf_r  <= ovf_nxt;
      warm_r <= warm_nxt;
      if (cfg_we) begin
        unique case (dpmpp_pkg::cfg_reg_t'(cfg_idx))
          dpmpp_pkg::REG_SIGMA_CUR:   cfg_r.sigma_cur <= cfg_wdata[23:0];
          dpmpp_pkg::REG_NORM_CUR:    cfg_r.norm_cur <= cfg_wdata[23:0];
          dpmpp_pkg::REG_SAMP_WEIGHT: cfg_r.samp_weight <= cfg_wdata[16:0];
          dpmpp_pkg::REG_STEP_COEF:   cfg_r.step_coef <= $signed(cfg_wdata[16:0]);
          dpmpp_pkg::REG_INV_RATIO:   cfg_r.inv_ratio <= $signed(cfg_wdata[24:0]);
          dpmpp_pkg::REG_HIST_ORDER:  cfg_r.hist_order <= cfg_wdata[1:0];
          dpmpp_pkg::REG_FIRST_FINAL: cfg_r.first_final <= cfg_wdata[0];
          dpmpp_pkg::REG_FINAL_STEP:  cfg_r.final_step <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/dpmpp_pred.sv
// stages one and two: clean-data prediction and sample weighting products
module dpmpp_pred #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en_s1,
  input  logic                                en_s2,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] sample,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] eps,
  input  dpmpp_pkg::cfg_t                     cfg,
  output logic signed [dpmpp_pkg::DATA_W-1:0] x0,
  output logic signed [49:0]                  ss
);

  localparam logic signed [57:0] X0_HALF = 58'sd1 <<< (FRAC_BITS - 1);

  logic signed [56:0]                  sn_r, se_r;
  logic signed [49:0]                  ss1_r, ss2_r;
  logic signed [dpmpp_pkg::DATA_W-1:0] x0_r, x0_nxt;
  logic signed [57:0]                  diff, rnd;

  always_comb begin
    diff   = {sn_r[56], sn_r} - {se_r[56], se_r};
    rnd    = (diff + X0_HALF) >>> FRAC_BITS;
    x0_nxt = dpmpp_pkg::sat32(dpmpp_pkg::SAT_IN_W'(rnd));
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      sn_r  <= sample * $signed({1'b0, cfg.norm_cur});
      se_r  <= eps * $signed({1'b0, cfg.sigma_cur});
      ss1_r <= sample * $signed({1'b0, cfg.samp_weight});
    end
    if (en_s2) begin
      x0_r  <= x0_nxt;
      ss2_r <= ss1_r;
    end
  end

  assign x0 = x0_r;
  assign ss = ss2_r;

endmodule

// File: rtl/core/dpmpp_hist.sv
// per-element store of the previous step's prediction, registered read
module dpmpp_hist #(
  parameter int MAX_ELEMENTS = 16384,
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic                                wr_en,
  input  logic [IDX_W-1:0]                    addr,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] wdata,
  output logic signed [dpmpp_pkg::DATA_W-1:0] rdata
);

  logic signed [dpmpp_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [dpmpp_pkg::DATA_W-1:0] rdata_r;

  // read returns the old entry when the same beat writes it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/dpmpp_upd.sv
// stages three to seven: midpoint correction and final sample update
module dpmpp_upd #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en_s3,
  input  logic                                en_s4,
  input  logic                                en_s5,
  input  logic                                en_s6,
  input  logic                                en_s7,
  input  dpmpp_pkg::cfg_t                     cfg,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] x0_in,
  input  logic signed [49:0]                  ss_in,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] m1,
  input  logic                                second,
  output logic signed [dpmpp_pkg::DATA_W-1:0] new_sample,
  output logic signed [dpmpp_pkg::DATA_W-1:0] clean_pred
);

  localparam int D1_W  = 58 - FRAC_BITS;
  localparam int CD_W  = 17 + D1_W;
  localparam int ACC_W = CD_W + 2;
  localparam logic signed [57:0]      PD_HALF  = 58'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< FRAC_BITS;

  logic signed [dpmpp_pkg::DATA_W-1:0] x03_r, x04_r, x05_r, x06_r;
  logic signed [49:0]                  ss3_r, ss4_r, ss5_r, ss6_r;
  logic signed [48:0]                  cx3_r, cx4_r, cx5_r, cx6_r;
  logic signed [57:0]                  pd4_r;
  logic signed [D1_W-1:0]              d15_r;
  logic signed [CD_W-1:0]              cd6_r;
  logic signed [dpmpp_pkg::DATA_W-1:0] ns_r, cp_r, ns_nxt;
  logic signed [32:0]                  dif;
  logic signed [ACC_W-1:0]             cd_sel, acc, rnd;

  assign dif = {x03_r[31], x03_r} - {m1[31], m1};

  // doubled terms so the half weight on d1 folds into one final rounding
  always_comb begin
    cd_sel = second ? ACC_W'(cd6_r) : ACC_W'(0);
    acc    = (ACC_W'(ss6_r) <<< 1) - (ACC_W'(cx6_r) <<< 1) - cd_sel;
    rnd    = (acc + ACC_HALF) >>> (FRAC_BITS + 1);
    ns_nxt = dpmpp_pkg::sat32(dpmpp_pkg::SAT_IN_W'(rnd));
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      x03_r <= x0_in;
      ss3_r <= ss_in;
      cx3_r <= x0_in * $signed(cfg.step_coef);
    end
    if (en_s4) begin
      x04_r <= x03_r;
      ss4_r <= ss3_r;
      cx4_r <= cx3_r;
      pd4_r <= dif * $signed(cfg.inv_ratio);
    end
    if (en_s5) begin
      x05_r <= x04_r;
      ss5_r <= ss4_r;
      cx5_r <= cx4_r;
      d15_r <= D1_W'((pd4_r + PD_HALF) >>> FRAC_BITS);
    end
    if (en_s6) begin
      x06_r <= x05_r;
      ss6_r <= ss5_r;
      cx6_r <= cx5_r;
      cd6_r <= d15_r * $signed(cfg.step_coef);
    end
    if (en_s7) begin
      ns_r <= ns_nxt;
      cp_r <= x06_r;
    end
  end

  assign new_sample = ns_r;
  assign clean_pred = cp_r;

endmodule

// File: rtl/core/dpm_solver_pp_update.sv
// top level of the dpm-solver++ second-order multistep update pipeline
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall | func, sample, eps, last_element
//  out_    | output    | out_valid/out_stall | new_sample, clean_pred, used_second_order,
//          |           |                     | overflow, last
//  cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata (write only)
//
// one beat per cycle sustained while out_stall stays low; an update beat loads stage
// one at its accepting edge and then passes through the seven register stages of the
// datapath (products, prediction rounding, history read, midpoint products and
// rounding, final sum) to the output register
// reset loads the configuration defaults and clears the element index, the overflow
// flag, the warm-up count and every stage valid bit; the history store is not cleared
// each stage holds while the one after it is full and held, so an empty stage
// is filled even under output stall and no beat is dropped or repeated
// clear beats (func set) only touch the step tracking and leave no result
module dpm_solver_pp_update #(
  parameter int MAX_ELEMENTS = 16384,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [dpmpp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dpmpp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] in_sample,
  input  logic signed [dpmpp_pkg::DATA_W-1:0] in_eps,
  input  logic                                in_last_element,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dpmpp_pkg::DATA_W-1:0] out_new_sample,
  output logic signed [dpmpp_pkg::DATA_W-1:0] out_clean_pred,
  output logic                                out_used_second_order,
  output logic                                out_overflow,
  output logic                                out_last
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int NS    = dpmpp_pkg::NUM_STAGES;

  dpmpp_pkg::cfg_t   cfg;
  dpmpp_pkg::flags_t flags_in;
  dpmpp_pkg::flags_t flg_r [1:NS];
  logic [IDX_W-1:0]  idx_in, idx1_r, idx2_r;

  logic [NS:1] v_r, v_nxt, en;
  logic        accept, upd_acc;

  logic signed [dpmpp_pkg::DATA_W-1:0] x0_2, m1_3;
  logic signed [49:0]                  ss_2;

  // stage enables ripple back from the output: a stage loads when it is empty
  // or when the stage after it moves on
  always_comb begin
    en[NS] = !v_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];
  assign accept   = in_valid && !in_stall;
  assign upd_acc  = accept && (in_func == dpmpp_pkg::FUNC_UPDATE);

  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      if (!en[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 1) begin
        v_nxt[k] = upd_acc;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // flags and store index travel beside the data
  always_ff @(posedge clk) begin
    if (en[1]) begin
      flg_r[1] <= flags_in;
      idx1_r   <= idx_in;
    end
    if (en[2]) begin
      idx2_r <= idx1_r;
    end
    for (int k = 2; k <= NS; k++) begin
      if (en[k]) begin
        flg_r[k] <= flg_r[k-1];
      end
    end
  end

  dpmpp_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .func         (in_func),
    .last_element (in_last_element),
    .cfg          (cfg),
    .flags        (flags_in),
    .idx          (idx_in)
  );

  dpmpp_pred #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pred (
    .clk    (clk),
    .en_s1  (en[1]),
    .en_s2  (en[2]),
    .sample (in_sample),
    .eps    (in_eps),
    .cfg    (cfg),
    .x0     (x0_2),
    .ss     (ss_2)
  );

  // read and write happen as a beat leaves stage two, so a later beat for the
  // same element always reads after the earlier write has landed
  dpmpp_hist #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_hist (
    .clk   (clk),
    .rd_en (en[3] && v_r[2]),
    .wr_en (en[3] && v_r[2] && !flg_r[2].ovf),
    .addr  (idx2_r),
    .wdata (x0_2),
    .rdata (m1_3)
  );

  dpmpp_upd #(
    .FRAC_BITS (FRAC_BITS)
  ) u_upd (
    .clk        (clk),
    .en_s3      (en[3]),
    .en_s4      (en[4]),
    .en_s5      (en[5]),
    .en_s6      (en[6]),
    .en_s7      (en[7]),
    .cfg        (cfg),
    .x0_in      (x0_2),
    .ss_in      (ss_2),
    .m1         (m1_3),
    .second     (flg_r[6].second),
    .new_sample (out_new_sample),
    .clean_pred (out_clean_pred)
  );

  assign out_valid             = v_r[NS];
  assign out_used_second_order = flg_r[NS].second;
  assign out_overflow          = flg_r[NS].ovf;
  assign out_last              = flg_r[NS].last;

endmodule
